// File: src/sstf_pkg.sv
`default_nettype none

package sstf_pkg;

    // sizing
    localparam int MAX_REQUESTERS = 16;
    localparam int TRACK_LIMIT    = 10000;
    localparam int SLOT_W         = $clog2(MAX_REQUESTERS);
    localparam int CNT_W          = $clog2(MAX_REQUESTERS + 1);
    localparam int TRACK_W        = 14;
    localparam int CFG_W          = 5;
    localparam int CFG_IDX_W      = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_QUEUE_DEPTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_REQUESTERS  = 1'd1;

    // actions
    localparam logic ACT_SUBMIT = 1'b0;
    localparam logic ACT_RETIRE = 1'b1;

    localparam logic [TRACK_W-1:0] TRACK_MAX = TRACK_W'(TRACK_LIMIT - 1);
    localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(MAX_REQUESTERS);

    typedef struct packed {
        logic               action;
        logic [SLOT_W-1:0]  requester;
        logic [TRACK_W-1:0] track;
    } t_sched_in;

    typedef struct packed {
        logic               accepted;
        logic               service_valid;
        logic [SLOT_W-1:0]  served_requester;
        logic [TRACK_W-1:0] served_track;
    } t_sched_out;

endpackage

`default_nettype wire

// File: src/sstf_disk_request_scheduler.sv
// channel   ports                                      handshake
// command   start, busy, i_item (t_sched_in)           taken when start & !busy
// result    o_result_valid, o_result (t_sched_out)     one-cycle strobe, no stall
// config    i_cfg_we, i_cfg_index, i_cfg_wdata         written when i_cfg_we
//
// a served command goes through accept, service check, a serial scan of the
// 16 slots through one distance/compare unit and one slot memory read port,
// then the update; when no request is served the scan is skipped.
// busy stays high from acceptance until the result strobe.
// i_rst_n is synchronous and active low; the slot track memory is not cleared.
// the result strobe lasts one cycle and cannot be held off.
`default_nettype none

module sstf_disk_request_scheduler
    import sstf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire t_sched_in            i_item,
    output logic                      o_result_valid,
    output t_sched_out                o_result,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EVAL = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    localparam logic [CNT_W-1:0] SLOTS = CNT_W'(MAX_REQUESTERS);

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_max_depth;
    logic [CFG_W-1:0] r_num_req;

    logic [TRACK_W-1:0]        r_slot_track [MAX_REQUESTERS];
    logic [MAX_REQUESTERS-1:0] r_slot_pending;
    logic [MAX_REQUESTERS-1:0] r_slot_retired;
    logic [CNT_W-1:0]          r_pending_cnt;
    logic [CNT_W-1:0]          r_retired_cnt;
    logic [TRACK_W-1:0]        r_head;
    logic                      r_awaiting;

    logic r_accepted;
    logic r_serve;

    // scan state
    logic [CNT_W-1:0]   r_idx;
    logic               r_rd_vld;
    logic               r_rd_pend;
    logic [SLOT_W-1:0]  r_rd_slot;
    logic [TRACK_W-1:0] r_rd_track;
    logic               r_found;
    logic [SLOT_W-1:0]  r_best;
    logic [TRACK_W-1:0] r_best_track;
    logic [TRACK_W-1:0] r_best_dist;

    logic       r_out_vld;
    t_sched_out r_out;

    // admission of the incoming word
    logic               take;
    logic [CNT_W-1:0]   n_part;
    logic               who_ok;
    logic               admit_submit;
    logic               admit_retire;
    logic [TRACK_W-1:0] sat_track;

    assign take   = start && (r_state == ST_IDLE);
    assign n_part = (CNT_W'(r_num_req) > SLOTS) ? SLOTS : CNT_W'(r_num_req);
    assign who_ok = CNT_W'(i_item.requester) < n_part;
    assign sat_track = (i_item.track > TRACK_MAX) ? TRACK_MAX : i_item.track;

    assign admit_submit = take && who_ok && (i_item.action == ACT_SUBMIT)
                        && !r_slot_pending[i_item.requester]
                        && !r_slot_retired[i_item.requester]
                        && (r_pending_cnt < CNT_W'(r_max_depth));
    assign admit_retire = take && who_ok && (i_item.action == ACT_RETIRE)
                        && !r_slot_pending[i_item.requester]
                        && !r_slot_retired[i_item.requester];

    // service rule, evaluated on the updated counts
    logic [CNT_W-1:0] live;
    logic             serve_now;

    assign live = (r_retired_cnt >= n_part) ? '0 : n_part - r_retired_cnt;
    assign serve_now = (r_pending_cnt != '0)
                    && ((r_pending_cnt >= CNT_W'(r_max_depth))
                        || ((r_pending_cnt >= live)
                            && !(r_awaiting && (r_pending_cnt != n_part))));

    // shared distance and compare unit
    logic [TRACK_W:0]   diff;
    logic [TRACK_W-1:0] seek_dist;
    logic               better;

    assign diff      = {1'b0, r_rd_track} - {1'b0, r_head};
    assign seek_dist = diff[TRACK_W] ? TRACK_W'(-diff) : diff[TRACK_W-1:0];
    assign better    = r_rd_vld && r_rd_pend
                     && (!r_found || (seek_dist < r_best_dist));

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_EVAL;
            end
            ST_EVAL: begin
                n_state = serve_now ? ST_SCAN : ST_DONE;
            end
            ST_SCAN: begin
                if (r_idx == SLOTS) n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_depth <= CFG_RESET;
            r_num_req   <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MAX_QUEUE_DEPTH: r_max_depth <= i_cfg_wdata;
                REG_NUM_REQUESTERS:  r_num_req   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // slot track memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (admit_submit) r_slot_track[i_item.requester] <= sat_track;
        if (r_state == ST_SCAN) r_rd_track <= r_slot_track[r_idx[SLOT_W-1:0]];
    end

    // slot flags, counts and head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_pending <= '0;
            r_slot_retired <= '0;
            r_pending_cnt  <= '0;
            r_retired_cnt  <= '0;
            r_head         <= '0;
            r_awaiting     <= 1'b1;
        end else begin
            if (admit_submit) begin
                r_slot_pending[i_item.requester] <= 1'b1;
                r_pending_cnt <= r_pending_cnt + 1'b1;
            end
            if (admit_retire) begin
                r_slot_retired[i_item.requester] <= 1'b1;
                r_retired_cnt <= r_retired_cnt + 1'b1;
            end
            if ((r_state == ST_DONE) && r_serve && r_found) begin
                r_slot_pending[r_best] <= 1'b0;
                r_pending_cnt <= r_pending_cnt - 1'b1;
                r_head        <= r_best_track;
                r_awaiting    <= 1'b0;
            end
        end
    end

    // per-command flags
    always_ff @(posedge i_clk) begin
        if (take) r_accepted <= admit_submit || admit_retire;
        if (r_state == ST_EVAL) r_serve <= serve_now;
    end

    // scan over the slots, read stage then compare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
        end else if (r_state == ST_EVAL) begin
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
        end else if (r_state == ST_SCAN) begin
            r_rd_vld <= (r_idx != SLOTS);
            if (r_idx != SLOTS) r_idx <= r_idx + 1'b1;
            if (better) r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN) begin
            r_rd_slot <= r_idx[SLOT_W-1:0];
            r_rd_pend <= r_slot_pending[r_idx[SLOT_W-1:0]];
            if (better) begin
                r_best       <= r_rd_slot;
                r_best_track <= r_rd_track;
                r_best_dist  <= seek_dist;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= (r_state == ST_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE) begin
            r_out.accepted         <= r_accepted;
            r_out.service_valid    <= r_serve && r_found;
            r_out.served_requester <= (r_serve && r_found) ? r_best : '0;
            r_out.served_track     <= (r_serve && r_found) ? r_best_track : '0;
        end
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_out_vld;
    assign o_result       = r_out;

endmodule

`default_nettype wire

// File: test/sstf_disk_request_scheduler_test.sv
`timescale 1ns / 1ps

import sstf_pkg::*;

// tracks the scheduler's slots and head, predicts one result word per command
class sstf_scoreboard;
    int  slot_track [MAX_REQUESTERS];
    bit  slot_busy  [MAX_REQUESTERS];
    bit  slot_gone  [MAX_REQUESTERS];
    int  queued;
    int  gone_count;
    int  head_pos;
    bit  first_pending;
    int  depth_limit;
    int  requester_cfg;
    t_sched_out due_results[$];
    int  err_count;
    int  commands, taken_submits, taken_retires, services, refusals;

    function new();
        for (int i = 0; i < MAX_REQUESTERS; i++) begin
            slot_track[i] = 0;
            slot_busy[i]  = 1'b0;
            slot_gone[i]  = 1'b0;
        end
        queued        = 0;
        gone_count    = 0;
        head_pos      = 0;
        first_pending = 1'b1;
        depth_limit   = int'(CFG_RESET);
        requester_cfg = int'(CFG_RESET);
        err_count     = 0;
        commands      = 0;
        taken_submits = 0;
        taken_retires = 0;
        services      = 0;
        refusals      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        if (idx == REG_MAX_QUEUE_DEPTH) begin
            depth_limit = int'(val);
        end else if (idx == REG_NUM_REQUESTERS) begin
            requester_cfg = int'(val);
        end
    endfunction

    // requesters taking part, capped at the slot count
    function int active_slots();
        return (requester_cfg > MAX_REQUESTERS) ? MAX_REQUESTERS : requester_cfg;
    endfunction

    function bit can_retire(int who);
        return (who < active_slots()) && !slot_busy[who] && !slot_gone[who];
    endfunction

    // apply one accepted command and queue the word it must produce
    function void note_command(t_sched_in cmd);
        t_sched_out exp_word;
        int n, who, trk, live, best, best_dist, seek_dist;
        bit serve;
        exp_word = '0;
        n   = active_slots();
        who = int'(cmd.requester);
        trk = (int'(cmd.track) >= TRACK_LIMIT) ? TRACK_LIMIT - 1 : int'(cmd.track);
        commands++;

        // submit or retire
        if (who < n) begin
            if (cmd.action == ACT_SUBMIT) begin
                if (!slot_busy[who] && !slot_gone[who] && queued < depth_limit) begin
                    slot_track[who] = trk;
                    slot_busy[who]  = 1'b1;
                    queued++;
                    exp_word.accepted = 1'b1;
                    taken_submits++;
                end
            end else if (!slot_gone[who] && !slot_busy[who]) begin
                slot_gone[who] = 1'b1;
                gone_count++;
                exp_word.accepted = 1'b1;
                taken_retires++;
            end
        end
        if (!exp_word.accepted) refusals++;

        // service decision
        live  = (gone_count >= n) ? 0 : n - gone_count;
        serve = (queued > 0) &&
                ((queued >= depth_limit) ||
                 ((queued >= live) && !(first_pending && queued != n)));

        // nearest pending track, lowest slot on a tie
        if (serve) begin
            best      = -1;
            best_dist = 0;
            for (int i = 0; i < MAX_REQUESTERS; i++) begin
                if (slot_busy[i]) begin
                    seek_dist = (slot_track[i] > head_pos) ? slot_track[i] - head_pos
                                                           : head_pos - slot_track[i];
                    if (best < 0 || seek_dist < best_dist) begin
                        best      = i;
                        best_dist = seek_dist;
                    end
                end
            end
            first_pending   = 1'b0;
            head_pos        = slot_track[best];
            slot_busy[best] = 1'b0;
            queued--;
            exp_word.service_valid    = 1'b1;
            exp_word.served_requester = SLOT_W'(best);
            exp_word.served_track     = TRACK_W'(head_pos);
            services++;
        end
        due_results.push_back(exp_word);
    endfunction

    function void check_result(t_sched_out got);
        t_sched_out exp_word;
        if (due_results.size() == 0) begin
            $error("result word with nothing expected: %h", got);
            err_count++;
            return;
        end
        exp_word = due_results.pop_front();
        if (got.accepted !== exp_word.accepted) begin
            $error("accepted: expected %0d, got %0d", exp_word.accepted, got.accepted);
            err_count++;
        end
        if (got.service_valid !== exp_word.service_valid) begin
            $error("service_valid: expected %0d, got %0d",
                   exp_word.service_valid, got.service_valid);
            err_count++;
        end
        if (got.served_requester !== exp_word.served_requester) begin
            $error("served_requester: expected %0d, got %0d",
                   exp_word.served_requester, got.served_requester);
            err_count++;
        end
        if (got.served_track !== exp_word.served_track) begin
            $error("served_track: expected %0d, got %0d",
                   exp_word.served_track, got.served_track);
            err_count++;
        end
    endfunction
endclass

module sstf_disk_request_scheduler_test;

    localparam int CYCLE_LIMIT = 400000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_sched_in            i_item;
    logic                 o_result_valid;
    t_sched_out           o_result;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_wdata;

    sstf_scoreboard sb = new();
    int cycle_count;
    int calm_left;
    int settings_seen;

    sstf_disk_request_scheduler i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("TEST FAILED");
        $finish;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            sb.check_result(o_result);
        end
    end

    function t_sched_in make_cmd(logic act, int who, int trk);
        t_sched_in cmd;
        cmd.action    = act;
        cmd.requester = SLOT_W'(who);
        cmd.track     = TRACK_W'(trk);
        return cmd;
    endfunction

    // track choice biased toward the head, ties and the range ends
    function int pick_track();
        int roll, j, t;
        roll = $urandom_range(0, 99);
        j    = $urandom_range(0, MAX_REQUESTERS - 1);
        if (roll < 50) return $urandom_range(0, TRACK_LIMIT - 1);
        if (roll < 62) begin
            t = sb.head_pos + $urandom_range(0, 40) - 20;
            return (t < 0) ? 0 : (t > TRACK_LIMIT - 1) ? TRACK_LIMIT - 1 : t;
        end
        if (roll < 80 && sb.slot_busy[j]) begin
            // same distance on the other side of the head, or the very same track
            t = (roll < 72) ? 2 * sb.head_pos - sb.slot_track[j] : sb.slot_track[j];
            if (t >= 0 && t < TRACK_LIMIT) return t;
        end
        if (roll < 90) begin
            case ($urandom_range(0, 3))
                0: return 0;
                1: return TRACK_LIMIT - 1;
                2: return TRACK_LIMIT;
                default: return (1 << TRACK_W) - 1;
            endcase
        end
        return $urandom_range(0, (1 << TRACK_W) - 1);
    endfunction

    // mostly submits from free requesters, some retires, some noise
    function t_sched_in next_cmd();
        t_sched_in cmd;
        int free_slots[$];
        int roll, who;
        roll = $urandom_range(0, 99);
        cmd  = make_cmd(ACT_SUBMIT, $urandom_range(0, MAX_REQUESTERS - 1), pick_track());
        if (roll < 82) begin
            for (int i = 0; i < sb.active_slots(); i++) begin
                if (!sb.slot_busy[i] && !sb.slot_gone[i]) free_slots.push_back(i);
            end
            if (free_slots.size() > 0) begin
                cmd.requester = SLOT_W'(free_slots[$urandom_range(0, free_slots.size() - 1)]);
            end
        end else if (roll < 86) begin
            cmd.action = ACT_RETIRE;
        end else begin
            cmd.action = logic'($urandom_range(0, 1));
            cmd.track  = TRACK_W'($urandom_range(0, (1 << TRACK_W) - 1));
        end
        // keep live retirements to a few high slots so small settings stay alive
        who = int'(cmd.requester);
        if (cmd.action == ACT_RETIRE && sb.can_retire(who) &&
            !(who >= 10 && sb.gone_count < 5)) begin
            cmd.action = ACT_SUBMIT;
        end
        return cmd;
    endfunction

    // gap before each command, with runs of back-to-back commands
    function int draw_gap();
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    // present one command word and hold it until taken
    task send_cmd(input t_sched_in cmd);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= cmd;
        do @(posedge i_clk); while (busy);
        sb.note_command(cmd);
    endtask

    // stop sending and wait for every outstanding result
    task drain();
        start <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge i_clk);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= CFG_W'(val);
        @(posedge i_clk);
        sb.write_reg(idx, CFG_W'(val));
    endtask

    task set_regs(input int depth, input int n);
        drain();
        repeat (3) @(posedge i_clk);
        write_reg(REG_MAX_QUEUE_DEPTH, depth);
        write_reg(REG_NUM_REQUESTERS, n);
        i_cfg_we <= 1'b0;
        settings_seen++;
    endtask

    task run_phase(input int depth, input int n, input int count);
        set_regs(depth, n);
        repeat (count) begin
            if ($urandom_range(0, 59) == 0) drain();
            send_cmd(next_cmd());
        end
    endtask

    // stimulus
    initial begin
        start         <= 1'b0;
        i_item        <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_wdata   <= '0;
        i_rst_n       <= 1'b0;
        calm_left     = 0;
        settings_seen = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: first service waits for all sixteen, ties, saturation, refusals
        set_regs(16, 16);
        send_cmd(make_cmd(ACT_SUBMIT, 0, 0));
        send_cmd(make_cmd(ACT_SUBMIT, 0, 77));
        for (int i = 1; i <= 11; i++) send_cmd(make_cmd(ACT_SUBMIT, i, i * 613));
        send_cmd(make_cmd(ACT_SUBMIT, 12, TRACK_LIMIT - 1));
        send_cmd(make_cmd(ACT_SUBMIT, 13, TRACK_LIMIT));
        send_cmd(make_cmd(ACT_SUBMIT, 14, (1 << TRACK_W) - 1));
        send_cmd(make_cmd(ACT_SUBMIT, 15, 2));
        send_cmd(make_cmd(ACT_SUBMIT, 0, 5000));
        send_cmd(make_cmd(ACT_RETIRE, 15, 0));
        send_cmd(make_cmd(ACT_RETIRE, 15, 0));
        send_cmd(make_cmd(ACT_SUBMIT, 15, 300));
        send_cmd(make_cmd(ACT_RETIRE, 5, 0));

        // random phases, pending slots carry across register changes
        run_phase(16, 16, 150);
        run_phase(4, 16, 120);
        run_phase(1, 16, 80);
        run_phase(16, 8, 120);
        run_phase(31, 31, 120);
        run_phase(0, 16, 20);
        run_phase(16, 0, 20);
        run_phase(2, 3, 100);
        run_phase(8, 12, 120);
        run_phase(5, 16, 100);
        run_phase(16, 16, 80);

        drain();
        repeat (40) @(posedge i_clk);
        $display("ran %0d commands over %0d register settings: %0d submits and %0d retires",
                 sb.commands, settings_seen, sb.taken_submits, sb.taken_retires);
        $display("taken, %0d refused, %0d requests served", sb.refusals, sb.services);
        if (sb.err_count == 0 && sb.due_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            if (sb.due_results.size() != 0) begin
                $error("%0d results never arrived", sb.due_results.size());
            end
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
